[src/triangle_face_normal_macros.svh]
// Assertion macros for the face normal block.
// Both use the clock and reset names of the module that expands them.
`ifndef TRIANGLE_FACE_NORMAL_MACROS_SVH
`define TRIANGLE_FACE_NORMAL_MACROS_SVH
`ifndef SYNTH
`define TFN_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("face normal check failed");
`define TFN_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("face normal check failed");
`else
`define TFN_ASSERT_IMP(lbl, ante, cons)
`define TFN_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

[src/tfn_pkg.sv]
`timescale 1ns / 1ps
package tfn_pkg;

   localparam int AXES = 3;

   // per-item control that rides along the pipe
   typedef struct packed {
      logic            valid;
      logic [AXES-1:0] neg;
      logic            degen;
   } tfn_flags_type;

endpackage

[src/tfn_cross.sv]
`timescale 1ns / 1ps
module tfn_cross #(
   parameter int CW = 24
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   input  logic signed [CW-1:0]    v0_x,
   input  logic signed [CW-1:0]    v0_y,
   input  logic signed [CW-1:0]    v0_z,
   input  logic signed [CW-1:0]    v1_x,
   input  logic signed [CW-1:0]    v1_y,
   input  logic signed [CW-1:0]    v1_z,
   input  logic signed [CW-1:0]    v2_x,
   input  logic signed [CW-1:0]    v2_y,
   input  logic signed [CW-1:0]    v2_z,
   output tfn_pkg::tfn_flags_type  flags_out,
   output logic [2:0][2*(CW+1)-1:0] mag_out
);
   import tfn_pkg::*;

   localparam int DW  = CW + 1;
   localparam int PRW = 2 * DW;
   localparam int MW  = 2 * DW;

   logic [AXES-1:0][DW-1:0]  a_in, a_ff, b_in, b_ff;
   logic [AXES-1:0][PRW-1:0] pl_in, pl_ff, pr_in, pr_ff;
   logic [AXES-1:0][MW-1:0]  mag_in, mag_ff;
   logic [AXES-1:0]          neg_in, neg_ff;
   logic                     v1_ff, v2_ff, v3_ff;

   // edge vectors a = v2 - v1, b = v0 - v1
   always_comb begin
      a_in[0] = DW'(v2_x) - DW'(v1_x);
      a_in[1] = DW'(v2_y) - DW'(v1_y);
      a_in[2] = DW'(v2_z) - DW'(v1_z);
      b_in[0] = DW'(v0_x) - DW'(v1_x);
      b_in[1] = DW'(v0_y) - DW'(v1_y);
      b_in[2] = DW'(v0_z) - DW'(v1_z);
   end

   for (genvar i = 0; i < AXES; i++) begin : g_axis
      logic signed [PRW:0] c;
      assign pl_in[i] = PRW'($signed(a_ff[(i+1)%AXES]) * $signed(b_ff[(i+2)%AXES]));
      assign pr_in[i] = PRW'($signed(a_ff[(i+2)%AXES]) * $signed(b_ff[(i+1)%AXES]));
      always_comb begin
         c = (PRW+1)'($signed(pl_ff[i])) - (PRW+1)'($signed(pr_ff[i]));
         neg_in[i] = c[PRW];
         mag_in[i] = c[PRW] ? MW'(-c) : MW'(c);
      end
   end

   always_ff @(posedge clock) begin
      a_ff   <= a_in;
      b_ff   <= b_in;
      pl_ff  <= pl_in;
      pr_ff  <= pr_in;
      mag_ff <= mag_in;
      neg_ff <= neg_in;
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   assign flags_out = '{valid: v3_ff, neg: neg_ff, degen: 1'b0};
   assign mag_out   = mag_ff;

endmodule

[src/tfn_square.sv]
`timescale 1ns / 1ps
module tfn_square #(
   parameter int MW    = 50,
   parameter int SW    = 102,
   parameter int EW    = 132,
   parameter int SHIFT = 30
) (
   input  logic                   clock,
   input  logic                   reset,
   input  tfn_pkg::tfn_flags_type flags_in,
   input  logic [2:0][MW-1:0]     mag_in,
   output tfn_pkg::tfn_flags_type flags_out,
   output logic [SW-1:0]          s_out,
   output logic [2:0][EW-1:0]     e_out
);
   import tfn_pkg::*;

   localparam int LW = MW / 2;
   localparam int HW = MW - LW;
   localparam int QW = 2 * MW;

   logic [AXES-1:0][2*HW-1:0]  hh_ff;
   logic [AXES-1:0][HW+LW-1:0] hl_ff;
   logic [AXES-1:0][2*LW-1:0]  ll_ff;
   logic [AXES-1:0][QW-1:0]    sq_in, sq_ff;
   logic [AXES-1:0][EW-1:0]    e_in, e_ff;
   logic [SW-1:0]              s_in, s_ff;
   tfn_flags_type              fa_ff, fb_ff, fc_in, fc_ff;

   // split squares: hi*hi, hi*lo, lo*lo, then recombine
   for (genvar i = 0; i < AXES; i++) begin : g_axis
      always_ff @(posedge clock) begin
         hh_ff[i] <= (2*HW)'(mag_in[i][MW-1:LW] * mag_in[i][MW-1:LW]);
         hl_ff[i] <= (HW+LW)'(mag_in[i][MW-1:LW] * mag_in[i][LW-1:0]);
         ll_ff[i] <= (2*LW)'(mag_in[i][LW-1:0] * mag_in[i][LW-1:0]);
      end
      assign sq_in[i] = (QW'(hh_ff[i]) << (2*LW)) + (QW'(hl_ff[i]) << (LW+1))
                        + QW'(ll_ff[i]);
      assign e_in[i]  = EW'(sq_ff[i]) << SHIFT;
   end

   always_comb begin
      s_in = SW'(sq_ff[0]) + SW'(sq_ff[1]) + SW'(sq_ff[2]);
      fc_in = fb_ff;
      fc_in.degen = (s_in == '0);
   end

   always_ff @(posedge clock) begin
      sq_ff <= sq_in;
      s_ff  <= s_in;
      e_ff  <= e_in;
      if (reset) begin
         fa_ff <= '0;
         fb_ff <= '0;
         fc_ff <= '0;
      end else begin
         fa_ff <= flags_in;
         fb_ff <= fa_ff;
         fc_ff <= fc_in;
      end
   end

   assign flags_out = fc_ff;
   assign s_out     = s_ff;
   assign e_out     = e_ff;

endmodule

[src/tfn_root_step.sv]
`timescale 1ns / 1ps
module tfn_root_step #(
   parameter int SW     = 102,
   parameter int EW     = 132,
   parameter int PW     = 118,
   parameter int MBW    = 16,
   parameter int BITPOS = 0
) (
   input  logic                   clock,
   input  logic                   reset,
   input  tfn_pkg::tfn_flags_type flags_in,
   input  logic [SW-1:0]          s_in,
   input  logic [2:0][EW-1:0]     e_in,
   input  logic [2:0][PW-1:0]     p_in,
   input  logic [2:0][MBW-1:0]    m_in,
   output tfn_pkg::tfn_flags_type flags_out,
   output logic [SW-1:0]          s_out,
   output logic [2:0][EW-1:0]     e_out,
   output logic [2:0][PW-1:0]     p_out,
   output logic [2:0][MBW-1:0]    m_out
);
   import tfn_pkg::*;

   localparam int DLW = SW + 2 * MBW + 1;

   logic [AXES-1:0][EW-1:0]  e_nx, e_ff;
   logic [AXES-1:0][PW-1:0]  p_nx, p_ff;
   logic [AXES-1:0][MBW-1:0] m_nx, m_ff;
   logic [SW-1:0]            s_ff;
   tfn_flags_type            f_ff;

   // trial bit: (m + 2^j)^2 S - m^2 S = 2^(j+1) P + 2^(2j) S, with P = m S
   for (genvar i = 0; i < AXES; i++) begin : g_axis
      logic [DLW-1:0] delta;
      always_comb begin
         delta = (DLW'(p_in[i]) << (BITPOS + 1)) + (DLW'(s_in) << (2 * BITPOS));
         e_nx[i] = e_in[i];
         p_nx[i] = p_in[i];
         m_nx[i] = m_in[i];
         if (delta <= DLW'(e_in[i])) begin
            e_nx[i] = e_in[i] - EW'(delta);
            p_nx[i] = p_in[i] + (PW'(s_in) << BITPOS);
            m_nx[i] = m_in[i] | (MBW'(1) << BITPOS);
         end
      end
   end

   always_ff @(posedge clock) begin
      e_ff <= e_nx;
      p_ff <= p_nx;
      m_ff <= m_nx;
      s_ff <= s_in;
      if (reset) begin
         f_ff <= '0;
      end else begin
         f_ff <= flags_in;
      end
   end

   assign flags_out = f_ff;
   assign s_out     = s_ff;
   assign e_out     = e_ff;
   assign p_out     = p_ff;
   assign m_out     = m_ff;

endmodule

[src/triangle_face_normal.sv]
// Unit face normal of one triangle, fully pipelined.
// Throughput: one triangle per clock, sustained; busy stays low.
// Pipeline stages from start to rsp_valid:
//   3 cross-product stages, 3 squaring stages, one root stage per result bit, 1 output.
// Synchronous reset clears every valid bit; data registers are not reset.
// No back pressure: each result shows on rsp_* for one cycle with rsp_valid.
`timescale 1ns / 1ps
`include "triangle_face_normal_macros.svh"
module triangle_face_normal #(
   parameter int COORD_WIDTH      = 24,
   parameter int NORMAL_FRAC_BITS = 14
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic signed [COORD_WIDTH-1:0]     req_v0_x,
   input  logic signed [COORD_WIDTH-1:0]     req_v0_y,
   input  logic signed [COORD_WIDTH-1:0]     req_v0_z,
   input  logic signed [COORD_WIDTH-1:0]     req_v1_x,
   input  logic signed [COORD_WIDTH-1:0]     req_v1_y,
   input  logic signed [COORD_WIDTH-1:0]     req_v1_z,
   input  logic signed [COORD_WIDTH-1:0]     req_v2_x,
   input  logic signed [COORD_WIDTH-1:0]     req_v2_y,
   input  logic signed [COORD_WIDTH-1:0]     req_v2_z,
   output logic                              rsp_valid,
   output logic signed [NORMAL_FRAC_BITS+1:0] rsp_normal_x,
   output logic signed [NORMAL_FRAC_BITS+1:0] rsp_normal_y,
   output logic signed [NORMAL_FRAC_BITS+1:0] rsp_normal_z,
   output logic                              rsp_degenerate
);
   import tfn_pkg::*;

   // Widths. c = a x b is exact; S = |c|^2; the root stages find the largest
   // m with m^2 S <= c^2 4^(F+1), so m = floor(2 |c| 2^F / sqrt(S)), and the
   // rounded-half-away result is (m + 1) >> 1.
   localparam int F     = NORMAL_FRAC_BITS;
   localparam int DW    = COORD_WIDTH + 1;
   localparam int MW    = 2 * DW;            // |c| magnitude
   localparam int SW    = 2 * MW + 2;        // sum of three squares
   localparam int EW    = 2 * MW + 2 * F + 2; // root residual
   localparam int MBW   = F + 2;             // root bits, also the output width
   localparam int PW    = SW + MBW;          // running m * S
   localparam int NW    = F + 2;

   tfn_flags_type            fx_flags, fs_flags;
   logic [AXES-1:0][MW-1:0]  mag;
   logic [SW-1:0]            s0;
   logic [AXES-1:0][EW-1:0]  e0;

   // root pipe taps, entry 0 feeds the top bit
   tfn_flags_type            f_pipe [0:MBW];
   logic [SW-1:0]            s_pipe [0:MBW];
   logic [AXES-1:0][EW-1:0]  e_pipe [0:MBW];
   logic [AXES-1:0][PW-1:0]  p_pipe [0:MBW];
   logic [AXES-1:0][MBW-1:0] m_pipe [0:MBW];

   logic [AXES-1:0][NW-1:0]  n_in, n_ff;
   logic                     valid_ff, degen_ff;

   // the pipe never stalls, so a new triangle is taken every cycle
   assign busy = 1'b0;

   tfn_cross #(.CW(COORD_WIDTH)) u_cross (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (start),
      .v0_x      (req_v0_x),
      .v0_y      (req_v0_y),
      .v0_z      (req_v0_z),
      .v1_x      (req_v1_x),
      .v1_y      (req_v1_y),
      .v1_z      (req_v1_z),
      .v2_x      (req_v2_x),
      .v2_y      (req_v2_y),
      .v2_z      (req_v2_z),
      .flags_out (fx_flags),
      .mag_out   (mag)
   );

   tfn_square #(.MW(MW), .SW(SW), .EW(EW), .SHIFT(2 * F + 2)) u_square (
      .clock     (clock),
      .reset     (reset),
      .flags_in  (fx_flags),
      .mag_in    (mag),
      .flags_out (fs_flags),
      .s_out     (s0),
      .e_out     (e0)
   );

   assign f_pipe[0] = fs_flags;
   assign s_pipe[0] = s0;
   assign e_pipe[0] = e0;
   assign p_pipe[0] = '0;
   assign m_pipe[0] = '0;

   // one stage per root bit, most significant first
   for (genvar b = 0; b < MBW; b++) begin : g_root
      tfn_root_step #(
         .SW(SW), .EW(EW), .PW(PW), .MBW(MBW), .BITPOS(MBW - 1 - b)
      ) u_step (
         .clock     (clock),
         .reset     (reset),
         .flags_in  (f_pipe[b]),
         .s_in      (s_pipe[b]),
         .e_in      (e_pipe[b]),
         .p_in      (p_pipe[b]),
         .m_in      (m_pipe[b]),
         .flags_out (f_pipe[b+1]),
         .s_out     (s_pipe[b+1]),
         .e_out     (e_pipe[b+1]),
         .p_out     (p_pipe[b+1]),
         .m_out     (m_pipe[b+1])
      );
   end

   // round half away from zero, restore the sign; degenerate forces zero
   for (genvar i = 0; i < AXES; i++) begin : g_out
      logic [MBW-1:0] k;
      always_comb begin
         k = (m_pipe[MBW][i] + MBW'(1)) >> 1;
         if (f_pipe[MBW].degen) begin
            n_in[i] = '0;
         end else if (f_pipe[MBW].neg[i]) begin
            n_in[i] = NW'(-k);
         end else begin
            n_in[i] = NW'(k);
         end
      end
   end

   always_ff @(posedge clock) begin
      n_ff     <= n_in;
      degen_ff <= f_pipe[MBW].degen;
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= f_pipe[MBW].valid;
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_normal_x   = $signed(n_ff[0]);
   assign rsp_normal_y   = $signed(n_ff[1]);
   assign rsp_normal_z   = $signed(n_ff[2]);
   assign rsp_degenerate = degen_ff;

   // a degenerate triangle delivers the zero vector
   `TFN_ASSERT_IMP(a_degen_zero, rsp_valid && rsp_degenerate,
      rsp_normal_x == '0 && rsp_normal_y == '0 && rsp_normal_z == '0)
   // a nonzero cross product always has a component of at least 1/sqrt(3)
   `TFN_ASSERT_IMP(a_nonzero, rsp_valid && !rsp_degenerate,
      rsp_normal_x != '0 || rsp_normal_y != '0 || rsp_normal_z != '0)
   // the x component of the output stays within +/-2^F
   `TFN_ASSERT_NXT(a_root_bound, f_pipe[MBW].valid && !f_pipe[MBW].degen,
      $signed(rsp_normal_x) <= $signed(NW'(1) << F)
      && $signed(rsp_normal_x) >= -$signed(NW'(1) << F))

endmodule

[test/tb.sv]
`timescale 1ns / 1ps
module tb;

   localparam int CW          = 24;   // coordinate width
   localparam int FB          = 14;   // normal fraction bits
   localparam int NW          = FB + 2;
   localparam int LATENCY     = FB + 9;
   localparam int CYCLE_LIMIT = 400000;
   localparam int RAND_ITEMS  = 730;

   typedef logic signed [CW-1:0] coord_type;
   typedef logic [191:0] big_type;

   // one triangle: v0 xyz, v1 xyz, v2 xyz
   typedef struct {
      coord_type c[9];
   } triangle_type;

   typedef struct {
      logic signed [NW-1:0] nx;
      logic signed [NW-1:0] ny;
      logic signed [NW-1:0] nz;
      logic                 degen;
   } normal_type;

   // Keeps the normals still owed by the block, oldest first.
   class normal_scoreboard;
      normal_type owed[$];
      int         errors;

      function new();
         errors = 0;
      endfunction

      // round_half_away(comp * 2^FB / sqrt(len_sq)), exact
      function automatic logic [NW-1:0] scaled_comp(logic signed [63:0] comp,
                                                    big_type len_sq);
         logic [63:0] mag;
         big_type     target;
         big_type     lhs;
         big_type     odd;
         longint      lo;
         longint      hi;
         longint      mid;
         mag    = comp < 0 ? -comp : comp;
         target = big_type'(mag) * big_type'(mag);
         target = target << (2 * FB + 2);
         lo     = 0;
         hi     = longint'(1) << FB;
         // largest k with (2k-1)^2 * len_sq <= 4 * comp^2 * 2^(2FB)
         while (lo < hi) begin
            mid = lo + (hi - lo + 1) / 2;
            odd = big_type'(2 * mid - 1);
            lhs = odd * odd * len_sq;
            if (lhs <= target) lo = mid;
            else hi = mid - 1;
         end
         return comp < 0 ? NW'(-lo) : NW'(lo);
      endfunction

      function automatic normal_type face_normal(triangle_type t);
         logic signed [63:0] ax, ay, az, bx, by, bz;
         logic signed [63:0] cx, cy, cz;
         big_type            len_sq;
         normal_type         n;
         // a = v2 - v1, b = v0 - v1
         ax = 64'(t.c[6]) - 64'(t.c[3]);
         ay = 64'(t.c[7]) - 64'(t.c[4]);
         az = 64'(t.c[8]) - 64'(t.c[5]);
         bx = 64'(t.c[0]) - 64'(t.c[3]);
         by = 64'(t.c[1]) - 64'(t.c[4]);
         bz = 64'(t.c[2]) - 64'(t.c[5]);
         cx = ay * bz - az * by;
         cy = az * bx - ax * bz;
         cz = ax * by - ay * bx;
         len_sq = big_type'(cx < 0 ? -cx : cx) * big_type'(cx < 0 ? -cx : cx)
                + big_type'(cy < 0 ? -cy : cy) * big_type'(cy < 0 ? -cy : cy)
                + big_type'(cz < 0 ? -cz : cz) * big_type'(cz < 0 ? -cz : cz);
         if (len_sq == 0) begin
            n.nx = 0; n.ny = 0; n.nz = 0; n.degen = 1'b1;
         end else begin
            n.nx    = scaled_comp(cx, len_sq);
            n.ny    = scaled_comp(cy, len_sq);
            n.nz    = scaled_comp(cz, len_sq);
            n.degen = 1'b0;
         end
         return n;
      endfunction

      function void note_triangle(triangle_type t);
         owed = {owed, face_normal(t)};
      endfunction

      function void check_normal(normal_type got);
         normal_type want;
         if (owed.size() == 0) begin
            $error("normal with no triangle outstanding");
            errors++;
            return;
         end
         want = owed.pop_front();
         if (got.nx !== want.nx) begin
            $error("normal_x expected %0d actual %0d", want.nx, got.nx);
            errors++;
         end
         if (got.ny !== want.ny) begin
            $error("normal_y expected %0d actual %0d", want.ny, got.ny);
            errors++;
         end
         if (got.nz !== want.nz) begin
            $error("normal_z expected %0d actual %0d", want.nz, got.nz);
            errors++;
         end
         if (got.degen !== want.degen) begin
            $error("degenerate expected %0b actual %0b", want.degen, got.degen);
            errors++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   coord_type req_v0_x = '0, req_v0_y = '0, req_v0_z = '0;
   coord_type req_v1_x = '0, req_v1_y = '0, req_v1_z = '0;
   coord_type req_v2_x = '0, req_v2_y = '0, req_v2_z = '0;
   logic rsp_valid;
   logic signed [NW-1:0] rsp_normal_x, rsp_normal_y, rsp_normal_z;
   logic rsp_degenerate;

   normal_scoreboard sb = new();
   int cycles = 0;
   bit burst_mode = 1'b0;   // no idling while set

   always #2 clock = ~clock;

   triangle_face_normal #(.COORD_WIDTH(CW), .NORMAL_FRAC_BITS(FB)) u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_v0_x(req_v0_x), .req_v0_y(req_v0_y), .req_v0_z(req_v0_z),
      .req_v1_x(req_v1_x), .req_v1_y(req_v1_y), .req_v1_z(req_v1_z),
      .req_v2_x(req_v2_x), .req_v2_y(req_v2_y), .req_v2_z(req_v2_z),
      .rsp_valid(rsp_valid), .rsp_normal_x(rsp_normal_x), .rsp_normal_y(rsp_normal_y),
      .rsp_normal_z(rsp_normal_z), .rsp_degenerate(rsp_degenerate)
   );

   // Results can't be held off: check every strobed cycle at the closing edge.
   always @(posedge clock) begin
      normal_type got;
      if (!reset && rsp_valid === 1'b1) begin
         got.nx    = rsp_normal_x;
         got.ny    = rsp_normal_y;
         got.nz    = rsp_normal_z;
         got.degen = rsp_degenerate;
         sb.check_normal(got);
      end else if (!reset && rsp_valid !== 1'b0) begin
         $error("rsp_valid unknown");
         sb.errors++;
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // Idle gap: mostly none or short, now and then long.
   function automatic int pick_gap();
      int r;
      if (burst_mode) return 0;
      r = $urandom_range(99);
      if (r < 45) return 0;
      if (r < 92) return $urandom_range(3, 1);
      return $urandom_range(60, 15);
   endfunction

   // Drive one triangle; hold start until the transfer happens, then idle for the requested gap.
   // start is only dropped when a gap follows, so it never toggles within one step.
   task automatic send_triangle(triangle_type t, int gap);
      start    <= 1'b1;
      req_v0_x <= t.c[0]; req_v0_y <= t.c[1]; req_v0_z <= t.c[2];
      req_v1_x <= t.c[3]; req_v1_y <= t.c[4]; req_v1_z <= t.c[5];
      req_v2_x <= t.c[6]; req_v2_y <= t.c[7]; req_v2_z <= t.c[8];
      do @(posedge clock); while (busy !== 1'b0);
      sb.note_triangle(t);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   function automatic triangle_type make_tri(int a0, int a1, int a2, int b0, int b1, int b2,
                                             int d0, int d1, int d2);
      triangle_type t;
      t.c[0] = coord_type'(a0); t.c[1] = coord_type'(a1); t.c[2] = coord_type'(a2);
      t.c[3] = coord_type'(b0); t.c[4] = coord_type'(b1); t.c[5] = coord_type'(b2);
      t.c[6] = coord_type'(d0); t.c[7] = coord_type'(d1); t.c[8] = coord_type'(d2);
      return t;
   endfunction

   function automatic coord_type rand_coord(int span);
      if (span == 0) return coord_type'($urandom);
      return coord_type'(int'($urandom_range(2 * span)) - span);
   endfunction

   // Random triangle: full range, small, degenerate, corner-heavy or axis-aligned.
   function automatic triangle_type rand_triangle();
      triangle_type t;
      int           mode;
      int           span;
      int           k;
      coord_type    corner[4];
      corner[0] = coord_type'(24'h7FFFFF);
      corner[1] = coord_type'(24'h800000);
      corner[2] = '0;
      corner[3] = coord_type'(-1);
      mode = $urandom_range(99);
      span = (mode % 3 == 0) ? 0 : (1 << $urandom_range(20, 1));
      for (int i = 0; i < 9; i++) t.c[i] = rand_coord(span);
      if (mode < 12) begin
         // collinear: v2 = v1 + k * (v0 - v1), or a repeated vertex
         span = 1 << $urandom_range(12, 1);
         for (int i = 0; i < 9; i++) t.c[i] = rand_coord(span);
         k = int'($urandom_range(6)) - 3;
         for (int i = 0; i < 3; i++)
            t.c[6 + i] = t.c[3 + i] + coord_type'(k) * (t.c[i] - t.c[3 + i]);
      end else if (mode < 20) begin
         for (int i = 0; i < 9; i++)
            if ($urandom_range(1)) t.c[i] = corner[$urandom_range(3)];
      end else if (mode < 26) begin
         // axis-aligned plane, normal along one axis
         k = $urandom_range(2);
         t.c[3 + k] = t.c[k];
         t.c[6 + k] = t.c[k];
      end
      return t;
   endfunction

   initial begin
      triangle_type dir_q[$];
      int           sent;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: zero/degenerate, unit axes, orientation flip, extremes, equal-component ties
      dir_q = {dir_q, make_tri(0, 0, 0, 0, 0, 0, 0, 0, 0)};
      dir_q = {dir_q, make_tri(5, 5, 5, 5, 5, 5, 5, 5, 5)};
      dir_q = {dir_q, make_tri(0, 1, 0, 0, 0, 0, 1, 0, 0)};
      dir_q = {dir_q, make_tri(1, 0, 0, 0, 0, 0, 0, 1, 0)};
      dir_q = {dir_q, make_tri(0, 0, 1, 0, 0, 0, 0, 1, 0)};
      dir_q = {dir_q, make_tri(0, 1, 0, 0, 0, 0, 0, 0, 1)};
      dir_q = {dir_q, make_tri(1, 0, 0, 0, 0, 0, 0, 0, 1)};
      dir_q = {dir_q, make_tri(0, 0, 1, 0, 0, 0, 1, 0, 0)};
      dir_q = {dir_q, make_tri(1, 0, 0, 0, 1, 0, 0, 0, 1)};
      dir_q = {dir_q, make_tri(0, 1, 0, 1, 0, 0, 0, 0, 1)};
      dir_q = {dir_q, make_tri(1, 1, 0, 0, 0, 0, 1, 0, 1)};
      dir_q = {dir_q, make_tri(3, 4, 0, 0, 0, 0, 0, 0, 7)};
      dir_q = {dir_q, make_tri(1, 2, 3, 2, 4, 6, 3, 6, 9)};
      dir_q = {dir_q, make_tri(8388607, 8388607, 8388607, -8388608, -8388608, -8388608,
                               8388607, -8388608, 8388607)};
      dir_q = {dir_q, make_tri(-8388608, 0, 0, 8388607, 0, 0, 8388607, 8388607, 0)};
      dir_q = {dir_q, make_tri(8388607, -8388608, 0, -8388608, 8388607, 0,
                               0, 0, -8388608)};
      dir_q = {dir_q, make_tri(-8388608, -8388608, -8388608, 8388607, 8388607, 8388607,
                               -8388608, 8388607, -8388608)};
      dir_q = {dir_q, make_tri(-8388608, -8388608, -8388608, -8388608, -8388608, -8388608,
                               8388607, 8388607, 8388607)};
      dir_q = {dir_q, make_tri(-1, -1, -1, 0, 0, 0, 1, 1, 1)};
      dir_q = {dir_q, make_tri(1, 0, 0, 0, 0, 0, 1, 1, 1)};
      burst_mode = 1'b1;
      foreach (dir_q[i]) send_triangle(dir_q[i], (i == dir_q.size() - 1) ? 1 : 0);

      // let the pipe drain completely before the random part
      while (sb.owed.size() != 0) @(posedge clock);

      sent = 0;
      while (sent < RAND_ITEMS) begin
         if (sent % 50 == 0) burst_mode = ($urandom_range(3) == 0);
         send_triangle(rand_triangle(), pick_gap());
         sent++;
         if (sent == RAND_ITEMS / 2) begin
            start <= 1'b0;
            @(posedge clock);
            while (sb.owed.size() != 0) @(posedge clock);
         end
      end
      start <= 1'b0;
      @(posedge clock);
      while (sb.owed.size() != 0) @(posedge clock);
      repeat (LATENCY + 8) @(posedge clock);

      if (sb.errors == 0 && sb.owed.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
